/* src/sbpe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sbpe_pkg;

  localparam int NUM_BANDS_DEF = 32;
  localparam int NUM_BINS_DEF = 512;

  typedef enum logic [1:0] {
    CMD_LOAD_EDGE = 2'd0,
    CMD_POOL      = 2'd1,
    CMD_STORE     = 2'd2,
    CMD_EXPAND    = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    KIND_POOL   = 1'b0,
    KIND_EXPAND = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_CLEAR,
    ST_POOL_RD,
    ST_POOL_CHK,
    ST_EXP_C0,
    ST_EXP_MAP,
    ST_EXP_B,
    ST_EXP_LO,
    ST_EXP_HI,
    ST_EXP_DEC,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_t;

  // Request and status between the sequencer and the shared divider.
  typedef struct packed {
    logic        start;
    logic [40:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [40:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

/* src/sbpe_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
module sbpe_divider
  import sbpe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  // Restoring division, one quotient bit per cycle.
  logic [40:0] quo;
  logic [17:0] rem;
  logic [16:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [17:0] trial;

  assign trial = {rem[16:0], quo[40]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
        cnt  <= 6'd41;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
          quo <= {quo[39:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[39:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quotient = quo;

  assert property (@(posedge clk) disable iff (rst) rsp.done |-> !rsp.busy)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (rst) req.start |=> rsp.busy)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst) rsp.busy |-> cnt != 6'd0)
    else $error("divider count underflow");

endmodule
`default_nettype wire

/* src/spectral_band_pool_and_expand.sv */
`timescale 1ns / 1ps
`default_nettype none
// Band pooling and expansion over a spectral bin stream.
// Input channel s_axis: one transfer is one command (edge load, pool bin,
// store band value, expand bin). Output channel m_axis: pooled band means
// (tuser=0) and expanded bin values (tuser=1), tlast marks the top band.
// The block works on one command at a time; s_axis_tready is low meanwhile.
// A band value store completes on acceptance; an edge load then fills the
// map for its bins. A pooled bin reads the map and checks the range, and
// at a band end the mean is computed on the shared divider. An expansion
// reads the map, picks and reads two bands, then decides; when
// interpolating it runs the divider and then a multiply.
// After reset the bin-to-band map is cleared, one bin per cycle, while
// s_axis_tready stays low.
// A result waits in the output register while the receiver stalls; the next
// command is taken once the result transfer has completed.
module spectral_band_pool_and_expand
  import sbpe_pkg::*;
#(
  parameter int NUM_BANDS = NUM_BANDS_DEF,
  parameter int NUM_BINS  = NUM_BINS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] cmd, [6:2] band, [16:7] first_bin, [26:17] end_bin, [35:27] bin,
  // [67:36] sample, zero padded
  input  wire logic [71:0] s_axis_tdata,
  input  wire logic        m_axis_tready,
  output logic             m_axis_tvalid,
  // [8:0] index, [40:9] result, zero padded
  output logic [47:0]      m_axis_tdata,
  output logic             m_axis_tuser,  // kind
  output logic             m_axis_tlast   // last
);

  localparam int BW = $clog2(NUM_BANDS);
  localparam int KW = $clog2(NUM_BINS);
  localparam int CW = (KW >= 11) ? KW + 1 : 11;
  localparam logic [BW-1:0] TOP = BW'(NUM_BANDS - 1);
  localparam logic [40:0] SUM_MAX = {41{1'b1}};

  // Input fields.
  logic [1:0]  f_cmd;
  logic [4:0]  f_band;
  logic [9:0]  f_first;
  logic [9:0]  f_end;
  logic [8:0]  f_bin;
  logic [31:0] f_sample;
  assign f_cmd = s_axis_tdata[1:0];
  assign f_band = s_axis_tdata[6:2];
  assign f_first = s_axis_tdata[16:7];
  assign f_end = s_axis_tdata[26:17];
  assign f_bin = s_axis_tdata[35:27];
  assign f_sample = s_axis_tdata[67:36];

  // Storage.
  logic [9:0]    edge_first [NUM_BANDS];
  logic [9:0]    edge_end   [NUM_BANDS];
  logic [31:0]   band_store [NUM_BANDS];
  logic [BW-1:0] map_mem    [NUM_BINS];
  logic [BW-1:0] map_rd;

  logic [40:0]   pool_sum;
  logic [BW-1:0] pool_band;

  // Latched command.
  logic [8:0]    r_bin;
  logic [31:0]   r_sample;
  logic [BW-1:0] r_band;
  logic [CW-1:0] k_cur;
  logic [CW-1:0] k_stop;

  // Expansion work registers. Centres are signed, an empty band at bin 0
  // sits at -1.
  logic [BW-1:0]      b_cur;
  logic [BW-1:0]      lo;
  logic [BW-1:0]      hi;
  logic signed [11:0] c_lo;
  logic signed [11:0] c_hi;
  logic [31:0]        v_lo;
  logic [31:0]        v_hi;
  logic [15:0]        t_w;
  logic               is_pool;

  // Output register.
  logic          o_valid;
  logic          o_kind;
  logic [8:0]    o_index;
  logic [31:0]   o_result;
  logic          o_last;

  state_t   state, state_next;
  div_req_t dreq;
  div_rsp_t drsp;

  sbpe_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  function automatic logic signed [11:0] centre(input logic [9:0] f, input logic [9:0] e);
    centre = {2'b0, f} + {2'b0, e} - 12'd1;
  endfunction

  logic signed [11:0] x2;
  logic               accept;
  logic signed [11:0] c_b;
  logic signed [11:0] c_top;
  logic signed [11:0] c_zero;
  logic [9:0]  ef_b;
  logic [9:0]  ee_b;
  logic [41:0] sum_add;
  logic        sum_restart;
  logic [10:0] cnt_raw;
  logic [16:0] cnt;
  logic [31:0] dv;
  logic [47:0] prod;
  logic [31:0] p_hi;
  logic        clear_done;

  assign x2 = {2'b0, r_bin, 1'b0};
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && !o_valid;
  assign c_zero = centre(edge_first[0], edge_end[0]);
  assign c_top = centre(edge_first[TOP], edge_end[TOP]);
  assign ef_b = edge_first[b_cur];
  assign ee_b = edge_end[b_cur];
  assign c_b = centre(ef_b, ee_b);
  assign sum_restart = ({1'b0, r_bin} == ef_b) || (b_cur != pool_band);
  assign sum_add = {1'b0, pool_sum} + {10'd0, r_sample};
  assign cnt_raw = {1'b0, ee_b} - {1'b0, ef_b};
  assign cnt = (cnt_raw == 11'd0) ? 17'd1 : {6'd0, cnt_raw};
  assign dv = (v_hi >= v_lo) ? (v_hi - v_lo) : (v_lo - v_hi);
  assign prod = dv * {16'd0, t_w};
  assign p_hi = (v_hi >= v_lo) ? prod[47:16] : 32'(({16'd0, prod} + 64'd65535) >> 16);
  assign clear_done = k_cur == CW'(NUM_BINS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dreq.start = 1'b0;
    dreq.dividend = {pool_sum};
    dreq.divisor = cnt;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(f_cmd))
            CMD_LOAD_EDGE: state_next = (32'(f_band) < NUM_BANDS) ? ST_FILL : ST_IDLE;
            CMD_STORE:     state_next = ST_IDLE;
            CMD_POOL:      state_next = (32'(f_bin) < NUM_BINS) ? ST_POOL_RD : ST_IDLE;
            CMD_EXPAND:    state_next = (32'(f_bin) < NUM_BINS) ? ST_EXP_C0 : ST_IDLE;
            default:       state_next = ST_IDLE;
          endcase
        end
      end
      ST_FILL:     state_next = (k_cur >= k_stop) ? ST_IDLE : ST_FILL;
      ST_CLEAR:    state_next = clear_done ? ST_IDLE : ST_CLEAR;
      ST_POOL_RD:  state_next = ST_POOL_CHK;
      ST_POOL_CHK: begin
        if ({1'b0, r_bin} < ef_b || {1'b0, r_bin} >= ee_b) begin
          state_next = ST_IDLE;
        end else if ({1'b0, r_bin} + 10'd1 == ee_b) begin
          dreq.start = 1'b1;
          dreq.dividend = sum_restart ? {9'd0, r_sample}
                        : (sum_add[41] ? SUM_MAX : sum_add[40:0]);
          state_next = ST_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EXP_C0:  state_next = ST_EXP_MAP;
      ST_EXP_MAP: state_next = ST_EXP_B;
      ST_EXP_B:   state_next = ST_EXP_LO;
      ST_EXP_LO:  state_next = ST_EXP_HI;
      ST_EXP_HI:  state_next = ST_EXP_DEC;
      ST_EXP_DEC: begin
        if (c_hi <= c_lo || x2 <= c_lo || x2 >= c_hi) begin
          state_next = ST_OUT;
        end else begin
          dreq.start = 1'b1;
          dreq.dividend = {13'd0, x2 - c_lo, 16'd0};
          dreq.divisor = {5'd0, c_hi - c_lo};
          state_next = ST_DIV;
        end
      end
      ST_DIV:  state_next = drsp.done ? (is_pool ? ST_OUT : ST_MUL) : ST_DIV;
      ST_MUL:  state_next = ST_OUT;
      ST_OUT:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Map memory: one write and one registered read port. While idle the read
  // address follows the incoming bin so the entry is ready after the transfer.
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      map_mem[KW'(k_cur)] <= '0;
    end else if (state == ST_FILL && k_cur < k_stop) begin
      map_mem[KW'(k_cur)] <= r_band;
    end
    map_rd <= map_mem[(state == ST_IDLE) ? KW'(f_bin) : KW'(r_bin)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_sum  <= '0;
      pool_band <= '0;
      o_valid   <= 1'b0;
      k_cur     <= '0;
    end else begin
      if (o_valid && m_axis_tready) o_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: k_cur <= k_cur + CW'(1);
        ST_IDLE: begin
          if (accept) begin
            r_bin    <= f_bin;
            r_sample <= f_sample;
            r_band   <= BW'(f_band);
            k_cur    <= CW'(f_first);
            k_stop   <= (CW'(f_end) < CW'(NUM_BINS)) ? CW'(f_end) : CW'(NUM_BINS);
            if (cmd_t'(f_cmd) == CMD_LOAD_EDGE && 32'(f_band) < NUM_BANDS) begin
              edge_first[BW'(f_band)] <= f_first;
              edge_end[BW'(f_band)]   <= f_end;
            end
            if (cmd_t'(f_cmd) == CMD_STORE && 32'(f_band) < NUM_BANDS) begin
              band_store[BW'(f_band)] <= f_sample;
            end
          end
        end
        ST_FILL: k_cur <= k_cur + CW'(1);
        ST_POOL_RD: begin
          is_pool <= 1'b1;
          b_cur <= map_rd;
          o_kind <= KIND_POOL;
        end
        ST_POOL_CHK: begin
          if (!({1'b0, r_bin} < ef_b || {1'b0, r_bin} >= ee_b)) begin
            pool_band <= b_cur;
            if ({1'b0, r_bin} + 10'd1 == ee_b) pool_sum <= '0;
            else if (sum_restart) pool_sum <= {9'd0, r_sample};
            else pool_sum <= sum_add[41] ? SUM_MAX : sum_add[40:0];
            o_index <= 9'(b_cur);
            o_last <= (b_cur == TOP);
          end
        end
        ST_EXP_C0: begin
          is_pool <= 1'b0;
          o_kind <= KIND_EXPAND;
          o_index <= r_bin;
          o_last <= 1'b0;
          // Clamp both ends by forcing a degenerate pair.
          if (x2 <= c_zero) begin
            lo <= '0;
          end else begin
            lo <= TOP;
          end
        end
        ST_EXP_MAP: b_cur <= map_rd;
        ST_EXP_B: begin
          if (x2 <= c_zero || x2 >= c_top) begin
            hi <= lo;
          end else if (x2 < c_b) begin
            lo <= (b_cur != '0) ? b_cur - BW'(1) : '0;
            hi <= b_cur;
          end else begin
            lo <= b_cur;
            hi <= (b_cur != TOP) ? b_cur + BW'(1) : TOP;
          end
        end
        ST_EXP_LO: begin
          c_lo <= centre(edge_first[lo], edge_end[lo]);
          v_lo <= band_store[lo];
        end
        ST_EXP_HI: begin
          c_hi <= centre(edge_first[hi], edge_end[hi]);
          v_hi <= band_store[hi];
        end
        ST_EXP_DEC: begin
          if (c_hi <= c_lo || x2 <= c_lo) o_result <= v_lo;
          else o_result <= v_hi;
        end
        ST_DIV: begin
          if (drsp.done) begin
            if (is_pool) begin
              o_result <= (drsp.quotient[40:32] != '0) ? 32'hFFFF_FFFF
                        : drsp.quotient[31:0];
            end else begin
              t_w <= drsp.quotient[15:0];
            end
          end
        end
        ST_MUL: o_result <= (v_hi >= v_lo) ? v_lo + p_hi : v_lo - p_hi;
        ST_OUT: o_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata = {7'd0, o_result, o_index};
  assign m_axis_tuser = o_kind;
  assign m_axis_tlast = o_last;

  assert property (@(posedge clk) disable iff (rst) s_axis_tready |-> state == ST_IDLE)
    else $error("ready outside idle");
  assert property (@(posedge clk) disable iff (rst) state == ST_OUT |=> m_axis_tvalid)
    else $error("result not presented");
  assert property (@(posedge clk) disable iff (rst) dreq.start |-> !drsp.busy)
    else $error("divider restarted while busy");
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast)
    else $error("tlast on expansion result");

endmodule
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import sbpe_pkg::*;

  localparam int NB = NUM_BANDS_DEF;
  localparam int NK = NUM_BINS_DEF;

  typedef struct {
    cmd_t        cmd;
    logic [4:0]  band;
    logic [9:0]  fb;
    logic [9:0]  eb;
    logic [8:0]  bin;
    logic [31:0] sample;
  } cmd_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [8:0]  index;
    logic [31:0] value;
    logic        last;
  } band_out_t;

  typedef struct {
    cmd_item_t it;
    bit        typed;
    band_out_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tready = 1'b0;
  logic        m_axis_tvalid;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  spectral_band_pool_and_expand dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tready(m_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always #1 clk = ~clk;

  // Mirror of the block state.
  logic [9:0]  edge_lo [NB];
  logic [9:0]  edge_hi [NB];
  logic [4:0]  bin_map [NK];
  logic [31:0] band_val [NB];
  logic [40:0] run_sum;
  logic [4:0]  run_band;

  band_out_t   pending_q [$];
  int          mismatches = 0;
  int          sent = 0;
  int          pooled = 0;
  int          expanded = 0;
  bit          quiet = 1'b0;

  function automatic int centre(int b);
    return int'(edge_lo[b]) + int'(edge_hi[b]) - 1;
  endfunction

  function automatic logic [31:0] interp_bin(logic [8:0] k);
    int x, c0, c1, b, lo, hi;
    logic [31:0] vlo, vhi;
    longint unsigned t, d;
    x = 2 * int'(k);
    if (x <= centre(0)) return band_val[0];
    if (x >= centre(NB - 1)) return band_val[NB - 1];
    b = bin_map[k];
    lo = b;
    hi = b;
    if (x < centre(b)) lo = (b > 0) ? b - 1 : 0;
    else hi = (b + 1 < NB) ? b + 1 : NB - 1;
    c0 = centre(lo);
    c1 = centre(hi);
    vlo = band_val[lo];
    vhi = band_val[hi];
    if (c1 <= c0 || x <= c0) return vlo;
    if (x >= c1) return vhi;
    t = (longint'(x - c0) << 16) / longint'(c1 - c0);
    if (vhi >= vlo) begin
      d = longint'(vhi - vlo) * t;
      return vlo + 32'(d >> 16);
    end
    d = longint'(vlo - vhi) * t;
    return vlo - 32'((d + 65535) >> 16);
  endfunction

  // Updates the mirror and returns 1 when the item yields a result.
  function automatic bit predict(cmd_item_t it, output band_out_t r);
    int b, cnt;
    logic [41:0] acc;
    logic [40:0] mean;
    r = '{KIND_POOL, '0, '0, 1'b0};
    case (it.cmd)
      CMD_LOAD_EDGE: begin
        edge_lo[it.band] = it.fb;
        edge_hi[it.band] = it.eb;
        for (int k = it.fb; k < ((it.eb < NK) ? int'(it.eb) : NK); k++)
          bin_map[k] = it.band;
        return 0;
      end
      CMD_STORE: begin
        band_val[it.band] = it.sample;
        return 0;
      end
      CMD_POOL: begin
        b = bin_map[it.bin];
        if (it.bin < edge_lo[b] || it.bin >= edge_hi[b]) return 0;
        if (it.bin == edge_lo[b] || b != run_band) begin
          run_sum = 41'(it.sample);
        end else begin
          acc = run_sum + it.sample;
          run_sum = acc[41] ? {41{1'b1}} : acc[40:0];
        end
        run_band = b;
        if (it.bin + 1 != edge_hi[b]) return 0;
        cnt = edge_hi[b] - edge_lo[b];
        if (cnt == 0) cnt = 1;
        mean = run_sum / cnt;
        run_sum = '0;
        r = '{KIND_POOL, 9'(b), (mean > 41'hFFFF_FFFF) ? 32'hFFFF_FFFF : mean[31:0],
              b == NB - 1};
        return 1;
      end
      default: begin
        r = '{KIND_EXPAND, it.bin, interp_bin(it.bin), 1'b0};
        return 1;
      end
    endcase
  endfunction

  task automatic send(cmd_item_t it, bit typed = 0, band_out_t tres = '{KIND_POOL, 0, 0, 0});
    band_out_t r;
    quiet = (sent >= 700 && sent < 900);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, it.sample, it.bin, it.eb, it.fb, it.band, it.cmd};
    do @(posedge clk); while (!s_axis_tready);
    sent++;
    if (predict(it, r)) pending_q.push_back(typed ? tres : r);
  endtask

  function automatic cmd_item_t mk(cmd_t c, int band, int fb, int eb, int bin, logic [31:0] s);
    cmd_item_t it;
    it = '{c, 5'(band), 10'(fb), 10'(eb), 9'(bin), s};
    return it;
  endfunction

  task automatic program_bands(bit wide);
    int pos, w;
    pos = 0;
    for (int b = 0; b < NB; b++) begin
      if (wide) w = (b == 0) ? NK : 0;
      else if ($urandom_range(15) == 0) w = 0;
      else if ($urandom_range(15) == 0) w = $urandom_range(10, 30);
      else w = $urandom_range(1, 6);
      if (pos + w > NK) w = NK - pos;
      send(mk(CMD_LOAD_EDGE, b, pos, pos + w, 0, 0));
      pos += w;
    end
    for (int b = 0; b < NB; b++)
      send(mk(CMD_STORE, b, 0, 0, 0,
              ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom()));
  endtask

  always @(negedge clk)
    m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 13);

  always @(posedge clk) begin
    band_out_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{kind_t'(m_axis_tuser), m_axis_tdata[8:0], m_axis_tdata[40:9], m_axis_tlast};
      if (got.kind == KIND_POOL) pooled++;
      else expanded++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer idx=%0d val=%h",
                                       got.index, got.value);
      end else begin
        want = pending_q.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp kind=%0d idx=%0d val=%h last=%0d, got kind=%0d idx=%0d val=%h last=%0d",
                     want.kind, want.index, want.value, want.last,
                     got.kind, got.index, got.value, got.last);
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("spectral_band_pool_and_expand verification failed");
    $finish;
  end

  initial begin
    dir_row_t tab [$];
    cmd_item_t it;
    int pos, hi;
    for (int k = 0; k < NK; k++) bin_map[k] = '0;
    for (int b = 0; b < NB; b++) begin
      edge_lo[b] = '0;
      edge_hi[b] = '0;
      band_val[b] = '0;
    end
    run_sum = '0;
    run_band = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Regular layout: four bins per band, band 0 at full scale, band b at b << 16.
    for (int b = 0; b < NB; b++) send(mk(CMD_LOAD_EDGE, b, 4 * b, 4 * b + 4, 0, 0));
    for (int b = 0; b < NB; b++)
      send(mk(CMD_STORE, b, 0, 0, 0, (b == 0) ? 32'hFFFF_FFFF : 32'(b) << 16));

    for (int k = 0; k < 4; k++)
      tab.push_back('{mk(CMD_POOL, 0, 0, 0, k, 32'hFFFF_FFFF), k == 3,
                     '{KIND_POOL, 9'd0, 32'hFFFF_FFFF, 1'b0}});
    for (int k = 124; k < 128; k++)
      tab.push_back('{mk(CMD_POOL, 0, 0, 0, k, 0), k == 127,
                     '{KIND_POOL, 9'd31, 32'd0, 1'b1}});
    tab.push_back('{mk(CMD_EXPAND, 0, 0, 0, 0, 0), 1, '{KIND_EXPAND, 9'd0, 32'hFFFF_FFFF, 0}});
    tab.push_back('{mk(CMD_EXPAND, 0, 0, 0, 511, 0), 1,
                   '{KIND_EXPAND, 9'd511, 32'h001F_0000, 0}});
    tab.push_back('{mk(CMD_EXPAND, 0, 0, 0, 6, 0), 0, '{KIND_POOL, 0, 0, 0}});
    tab.push_back('{mk(CMD_EXPAND, 0, 0, 0, 41, 0), 0, '{KIND_POOL, 0, 0, 0}});
    // Band edges far out of range leave the map alone, so its bins fall outside.
    tab.push_back('{mk(CMD_LOAD_EDGE, 5, 1023, 1023, 0, 0), 0, '{KIND_POOL, 0, 0, 0}});
    tab.push_back('{mk(CMD_POOL, 0, 0, 0, 21, 32'h1234), 0, '{KIND_POOL, 0, 0, 0}});
    tab.push_back('{mk(CMD_EXPAND, 0, 0, 0, 21, 0), 0, '{KIND_POOL, 0, 0, 0}});
    tab.push_back('{mk(CMD_LOAD_EDGE, 5, 20, 24, 0, 0), 0, '{KIND_POOL, 0, 0, 0}});
    // An empty band never completes.
    tab.push_back('{mk(CMD_LOAD_EDGE, 6, 26, 26, 0, 0), 0, '{KIND_POOL, 0, 0, 0}});
    tab.push_back('{mk(CMD_POOL, 0, 0, 0, 25, 32'h55), 0, '{KIND_POOL, 0, 0, 0}});
    tab.push_back('{mk(CMD_POOL, 0, 0, 0, 26, 32'h55), 0, '{KIND_POOL, 0, 0, 0}});
    tab.push_back('{mk(CMD_LOAD_EDGE, 6, 24, 28, 0, 0), 0, '{KIND_POOL, 0, 0, 0}});
    tab.push_back('{mk(CMD_STORE, 0, 0, 0, 0, 0), 0, '{KIND_POOL, 0, 0, 0}});
    tab.push_back('{mk(CMD_EXPAND, 0, 0, 0, 0, 0), 1, '{KIND_EXPAND, 9'd0, 32'd0, 0}});
    foreach (tab[i]) send(tab[i].it, tab[i].typed, tab[i].res);

    // Saturating sum: one band spans every bin and a middle bin repeats.
    program_bands(1);
    send(mk(CMD_POOL, 0, 0, 0, 0, 32'hFFFF_FFFF));
    repeat (530) send(mk(CMD_POOL, 0, 0, 0, 7, 32'hFFFF_FFFF));
    send(mk(CMD_POOL, 0, 0, 0, 511, 32'hFFFF_FFFF));

    while (sent < 1000) begin
      program_bands(0);
      hi = edge_hi[NB - 1] < NK ? int'(edge_hi[NB - 1]) : NK;
      // Ascending pooling frame, now and then dropping or repeating a bin.
      pos = 0;
      while (pos < hi) begin
        it = mk(CMD_POOL, 0, 0, 0, pos,
                ($urandom_range(7) == 0) ? 32'hFFFF_FFFF : $urandom());
        if ($urandom_range(29) != 0) send(it);
        if ($urandom_range(29) != 0) pos++;
      end
      repeat (25) send(mk(CMD_EXPAND, 0, 0, 0,
                          ($urandom_range(3) == 0) ? $urandom_range(511)
                                                   : $urandom_range(hi + 4), 0));
      repeat (8) begin
        it = mk(cmd_t'($urandom_range(3)), $urandom_range(31), $urandom_range(1023),
                $urandom_range(1023), $urandom_range(511), $urandom());
        send(it);
      end
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Run covered %0d commands with %0d pooled means and %0d expanded bins,",
             sent, pooled, expanded);
    $display("over random band layouts, a saturating sum and empty or stray bands.");
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("spectral_band_pool_and_expand verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_q.size());
      $display("spectral_band_pool_and_expand verification failed");
    end
    $finish;
  end

endmodule
